@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file brc_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ hdl/brc_pkg.sv @@
// Package for the banker's request checker: constants, payload structs, command types.
// No dependencies.
package brc_pkg;
   localparam int MAX_PROCS_DEF = 8;
   localparam int MAX_RES_DEF   = 4;
   localparam int UNIT_BITS_DEF = 8;

   localparam logic [2:0] MODE_SET_MAX   = 3'd0;
   localparam logic [2:0] MODE_SET_ALLOC = 3'd1;
   localparam logic [2:0] MODE_SET_AVAIL = 3'd2;
   localparam logic [2:0] MODE_SET_REQ   = 3'd3;
   localparam logic [2:0] MODE_EVAL      = 3'd4;

   localparam logic [2:0] ST_GRANTED = 3'd0;
   localparam logic [2:0] ST_EXCEEDS = 3'd1;
   localparam logic [2:0] ST_WAIT    = 3'd2;
   localparam logic [2:0] ST_UNSAFE  = 3'd3;
   localparam logic [2:0] ST_BADPROC = 3'd4;

   localparam logic CSR_PROC_COUNT = 1'b0;
   localparam logic CSR_RES_COUNT  = 1'b1;

   typedef struct packed {
      logic [2:0] mode;
      logic [2:0] proc_index;
      logic [1:0] res_index;
      logic [7:0] amount;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [2:0] seq_proc;
      logic       last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // apply set item
      logic eval_chk;   // compute checks for the held item
      logic commit;     // tentative grant, init work
      logic visit;      // evaluate process at scan pointer
      logic rollback;
      logic pass_start;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic bad_proc;
      logic exceeds;
      logic must_wait;
      logic fits;
      logic last_proc;
      logic all_done;
      logic progress;
   } stat_type;
endpackage

@@ hdl/brc_datapath.sv @@
// Datapath: tables, work units, finished flags, scan pointer and sequence store.
// Depends on brc_pkg.
module brc_datapath #(
   parameter int MAX_PROCS = brc_pkg::MAX_PROCS_DEF,
   parameter int MAX_RES   = brc_pkg::MAX_RES_DEF,
   parameter int UNIT_BITS = brc_pkg::UNIT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  brc_pkg::req_type  item,
   input  brc_pkg::cmd_type  cmd,
   input  logic [3:0]        proc_count,
   input  logic [2:0]        res_count,
   input  logic [$clog2(MAX_PROCS)-1:0] rd_idx,
   output logic [2:0]        rd_proc,
   output logic [$clog2(MAX_PROCS+1)-1:0] n_used,
   output brc_pkg::stat_type stat
);
   import brc_pkg::*;
   localparam int PB = $clog2(MAX_PROCS);
   localparam int RB = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
   localparam int WB = UNIT_BITS + $clog2(MAX_PROCS) + 1;
   localparam int NB = $clog2(MAX_PROCS+1);
   localparam int MB = $clog2(MAX_RES+1);

   logic [UNIT_BITS-1:0] max_ff   [MAX_PROCS][MAX_RES];
   logic [UNIT_BITS-1:0] alloc_ff [MAX_PROCS][MAX_RES];
   logic [UNIT_BITS-1:0] avail_ff [MAX_RES];
   logic [UNIT_BITS-1:0] reqv_ff  [MAX_RES];
   logic [WB-1:0]        work_ff  [MAX_RES];
   logic [MAX_PROCS-1:0] fin_ff;
   logic [PB-1:0]        ptr_ff;
   logic [NB-1:0]        done_ff;
   logic                 prog_ff;
   logic [PB-1:0]        seq_ff [MAX_PROCS];
   logic                 bad_ff, exc_ff, wait_ff;

   logic [NB-1:0] n;
   logic [MB-1:0] m;
   logic [PB-1:0] ep;
   logic [RB-1:0] ri;
   logic fits;

   always_comb begin
      if (proc_count == 4'd0) n = NB'(1);
      else if (32'(proc_count) > MAX_PROCS) n = NB'(MAX_PROCS);
      else n = NB'(proc_count);
      if (res_count == 3'd0) m = MB'(1);
      else if (32'(res_count) > MAX_RES) m = MB'(MAX_RES);
      else m = MB'(res_count);
   end
   assign n_used = n;
   assign ep = PB'(item.proc_index);
   assign ri = RB'(item.res_index);

   always_comb begin
      fits = 1'b1;
      for (int j = 0; j < MAX_RES; j++)
         if (j < 32'(m) && (WB+1)'(max_ff[ptr_ff][j]) >
             (WB+1)'(alloc_ff[ptr_ff][j]) + (WB+1)'(work_ff[j]))
            fits = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (32'(item.res_index) < MAX_RES) begin
            case (item.mode)
               MODE_SET_MAX:   if (32'(item.proc_index) < MAX_PROCS)
                                  max_ff[ep][ri] <= UNIT_BITS'(item.amount);
               MODE_SET_ALLOC: if (32'(item.proc_index) < MAX_PROCS)
                                  alloc_ff[ep][ri] <= UNIT_BITS'(item.amount);
               MODE_SET_AVAIL: avail_ff[ri] <= UNIT_BITS'(item.amount);
               MODE_SET_REQ:   reqv_ff[ri] <= UNIT_BITS'(item.amount);
               default: ;
            endcase
         end
      end
      if (cmd.eval_chk) begin
         bad_ff  <= {1'b0, item.proc_index} >= 4'(n);
         exc_ff  <= 1'b0;
         wait_ff <= 1'b0;
         for (int j = 0; j < MAX_RES; j++) begin
            if (j < 32'(m)) begin
               if ((UNIT_BITS+1)'(max_ff[ep][j]) <
                   (UNIT_BITS+1)'(alloc_ff[ep][j]) + (UNIT_BITS+1)'(reqv_ff[j]))
                  exc_ff <= 1'b1;
               if (avail_ff[j] < reqv_ff[j]) wait_ff <= 1'b1;
            end
         end
      end
      if (cmd.commit) begin
         for (int j = 0; j < MAX_RES; j++) begin
            if (j < 32'(m)) begin
               avail_ff[j] <= avail_ff[j] - reqv_ff[j];
               alloc_ff[ep][j] <= alloc_ff[ep][j] + reqv_ff[j];
               work_ff[j] <= WB'(avail_ff[j] - reqv_ff[j]);
            end
         end
      end
      if (cmd.rollback) begin
         for (int j = 0; j < MAX_RES; j++) begin
            if (j < 32'(m)) begin
               avail_ff[j] <= avail_ff[j] + reqv_ff[j];
               alloc_ff[ep][j] <= alloc_ff[ep][j] - reqv_ff[j];
            end
         end
      end
      if (cmd.visit && !fin_ff[ptr_ff] && fits) begin
         for (int j = 0; j < MAX_RES; j++)
            if (j < 32'(m)) work_ff[j] <= work_ff[j] + WB'(alloc_ff[ptr_ff][j]);
         seq_ff[done_ff[PB-1:0]] <= ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff  <= '0;
         ptr_ff  <= '0;
         done_ff <= '0;
         prog_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            fin_ff  <= '0;
            ptr_ff  <= '0;
            done_ff <= '0;
            prog_ff <= 1'b0;
         end
         if (cmd.pass_start) prog_ff <= 1'b0;
         if (cmd.visit) begin
            if (!fin_ff[ptr_ff] && fits) begin
               fin_ff[ptr_ff] <= 1'b1;
               done_ff <= done_ff + NB'(1);
               prog_ff <= 1'b1;
            end
            if (NB'(ptr_ff) + NB'(1) >= n) ptr_ff <= '0;
            else ptr_ff <= ptr_ff + PB'(1);
         end
      end
   end

   assign rd_proc = 3'(seq_ff[rd_idx]);
   assign stat.bad_proc  = bad_ff;
   assign stat.exceeds   = exc_ff;
   assign stat.must_wait = wait_ff;
   assign stat.fits      = !fin_ff[ptr_ff] && fits;
   assign stat.last_proc = NB'(ptr_ff) + NB'(1) >= n;
   assign stat.all_done  = done_ff == n;
   assign stat.progress  = prog_ff;
endmodule

@@ hdl/brc_controller.sv @@
// Controller: sequences checks, scan passes and result output.
// Depends on brc_pkg.
module brc_controller #(
   parameter int MAX_PROCS = brc_pkg::MAX_PROCS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  brc_pkg::req_type  req_data,
   output brc_pkg::req_type  item,
   output brc_pkg::cmd_type  cmd,
   input  brc_pkg::stat_type stat,
   input  logic [$clog2(MAX_PROCS+1)-1:0] n_used,
   output logic [$clog2(MAX_PROCS)-1:0] rd_idx,
   input  logic [2:0]        rd_proc,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output brc_pkg::rsp_type  rsp_data
);
   import brc_pkg::*;
   localparam int PB = $clog2(MAX_PROCS);
   localparam int NB = $clog2(MAX_PROCS+1);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_CHECK  = 7'b0000010,
      S_DECIDE = 7'b0000100,
      S_SCAN   = 7'b0001000,
      S_PASS   = 7'b0010000,
      S_OUT    = 7'b0100000,
      S_DENY   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   req_type   item_ff;
   logic [2:0] deny_ff, deny_in;
   logic [NB-1:0] out_ff, out_in;
   logic accept;

   assign req_stall = state_ff != S_IDLE;
   assign accept = req_valid && !req_stall;
   assign item = item_ff;
   assign rd_idx = out_ff[PB-1:0];

   always_comb begin
      state_in = state_ff;
      deny_in = deny_ff;
      out_in = out_ff;
      cmd = '0;
      rsp_valid = 1'b0;
      rsp_data = '0;
      case (state_ff)
         S_IDLE: ;
         S_CHECK: begin
            cmd.eval_chk = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (stat.bad_proc || stat.exceeds || stat.must_wait) begin
               deny_in = stat.bad_proc ? ST_BADPROC :
                         stat.exceeds ? ST_EXCEEDS : ST_WAIT;
               state_in = S_DENY;
            end else begin
               cmd.commit = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.visit = 1'b1;
            if (stat.last_proc) state_in = S_PASS;
         end
         S_PASS: begin
            out_in = '0;
            if (stat.all_done) state_in = S_OUT;
            else if (!stat.progress) begin
               cmd.rollback = 1'b1;
               deny_in = ST_UNSAFE;
               state_in = S_DENY;
            end else begin
               cmd.pass_start = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            rsp_data.status = ST_GRANTED;
            rsp_data.seq_proc = rd_proc;
            rsp_data.last = out_ff + NB'(1) == n_used;
            if (!rsp_stall) begin
               out_in = out_ff + NB'(1);
               if (rsp_data.last) state_in = S_IDLE;
            end
         end
         S_DENY: begin
            rsp_valid = 1'b1;
            rsp_data.status = deny_ff;
            rsp_data.last = 1'b1;
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (accept) begin
         if (req_data.mode == MODE_EVAL) state_in = S_CHECK;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) item_ff <= req_data;
      deny_ff <= deny_in;
      out_ff <= out_in;
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

@@ hdl/bankers_request_checker.sv @@
// Top level of the banker's request checker; joins controller and datapath.
// Depends on brc_pkg, brc_controller, brc_datapath.
//
// Load items are taken one per cycle while idle. An evaluate item is
// checked and decided; unless denied, a safety scan of at most n passes of
// n visits follows (n = n_used), then results go out one per cycle
// while rsp_stall is low: a denial is one result, a grant n results. The
// input is stalled from evaluate acceptance until its last result is taken;
// the scan is bounded by the single shared need-versus-work comparator.
module bankers_request_checker #(
   parameter int MAX_PROCS = brc_pkg::MAX_PROCS_DEF,
   parameter int MAX_RES   = brc_pkg::MAX_RES_DEF,
   parameter int UNIT_BITS = brc_pkg::UNIT_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  brc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output brc_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [3:0]       csr_data
);
   import brc_pkg::*;
   localparam int PB = $clog2(MAX_PROCS);
   localparam int NB = $clog2(MAX_PROCS+1);

   logic [3:0] proc_count_ff;
   logic [2:0] res_count_ff;
   req_type   item, ld_item;
   cmd_type   cmd_c, cmd;
   stat_type  stat;
   logic [PB-1:0] rd_idx;
   logic [2:0] rd_proc;
   logic [NB-1:0] n_used;
   logic load_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         proc_count_ff <= 4'd8;
         res_count_ff  <= 3'd4;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PROC_COUNT: proc_count_ff <= csr_data;
            CSR_RES_COUNT:  res_count_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   assign load_go = req_valid && !req_stall && req_data.mode != MODE_EVAL;
   assign ld_item = load_go ? req_data : item;
   always_comb begin
      cmd = cmd_c;
      cmd.load = load_go;
   end

   brc_controller #(.MAX_PROCS(MAX_PROCS)) u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_data, .item, .cmd(cmd_c), .stat,
      .n_used, .rd_idx, .rd_proc, .rsp_valid, .rsp_stall, .rsp_data
   );

   brc_datapath #(.MAX_PROCS(MAX_PROCS), .MAX_RES(MAX_RES), .UNIT_BITS(UNIT_BITS)) u_dp (
      .clock, .reset, .item(ld_item), .cmd, .proc_count(proc_count_ff),
      .res_count(res_count_ff), .rd_idx, .rd_proc, .n_used, .stat
   );
endmodule

@@ hdl/brc_checker.sv @@
// Port-level checker for the banker's request checker, bound to the top level.
// Depends on brc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module brc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input brc_pkg::rsp_type rsp_data
);
   import brc_pkg::*;
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "rsp payload changed under stall")
   `ASSERT_CLK(a_busy, clock, reset, rsp_valid |-> req_stall, "input open while result pending")
   `ASSERT_CLK(a_deny_last, clock, reset, rsp_valid && rsp_data.status != ST_GRANTED |-> rsp_data.last && rsp_data.seq_proc == 3'd0, "denial not single final result")
   `ASSERT_CLK_NR(a_reset, clock, reset |=> !rsp_valid && !req_stall, "not idle after reset")
endmodule

bind bankers_request_checker brc_checker u_brc_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_data
);
